@@ design/pfsa_pkg.sv @@
`default_nettype none

package pfsa_pkg;

  localparam int unsigned DEFAULT_STACK_DEPTH = 32;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [31:0] ADDR_MAX = 32'hFFFF_FFFF;

  // Command codes on the request channel.
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_FREE  = 2'd2;

  // Status codes on the result channel.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_SKIP = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  // Configuration register indices.
  localparam logic [1:0] CFG_KERNEL_END  = 2'd0;
  localparam logic [1:0] CFG_FRAME_BYTES = 2'd1;
  localparam logic [1:0] CFG_USABLE_TYPE = 2'd2;

  localparam logic [31:0] RST_KERNEL_END  = 32'h0010_0000;
  localparam logic [31:0] RST_FRAME_BYTES = 32'd4096;
  localparam logic [31:0] RST_USABLE_TYPE = 32'd1;

  // Work kinds handed from the front end to the stack engine.
  localparam logic [1:0] KIND_SKIP  = 2'd0;
  localparam logic [1:0] KIND_PUSH  = 2'd1;
  localparam logic [1:0] KIND_ALLOC = 2'd2;

  typedef struct packed {
    logic [31:0] kernel_end;
    logic [31:0] frame_bytes;
    logic [31:0] usable_type;
  } cfg_t;

  typedef struct packed {
    logic [31:0] base;
    logic [31:0] size;
  } seg_t;

  typedef struct packed {
    logic [1:0] kind;
    seg_t       seg;
  } q_entry_t;

endpackage

`default_nettype wire

@@ design/pfsa_front.sv @@
`default_nettype none

module pfsa_front (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        cmd,
  input  wire logic [31:0]       region_type,
  input  wire logic [31:0]       region_base_low,
  input  wire logic [31:0]       region_base_high,
  input  wire logic [31:0]       region_len_low,
  input  wire logic [31:0]       region_len_high,
  input  wire logic [31:0]       freed_frame,
  input  wire pfsa_pkg::cfg_t    cfg,
  output logic                   wr_valid,
  input  wire logic              wr_ready,
  output pfsa_pkg::q_entry_t     wr_entry
);
  import pfsa_pkg::*;

  logic [32:0] sum;
  logic [31:0] seg_start;
  logic [31:0] seg_end;
  logic        usable;

  // The end saturates when the length reaches past 32 bits or the sum carries out.
  assign sum       = {1'b0, region_base_low} + {1'b0, region_len_low};
  assign seg_start = (region_base_low < cfg.kernel_end) ? cfg.kernel_end : region_base_low;
  assign seg_end   = (region_len_high != 32'd0 || sum[32]) ? ADDR_MAX : sum[31:0];
  assign usable    = (region_type == cfg.usable_type) && (region_base_high == 32'd0);

  always_comb begin
    wr_entry.kind     = KIND_SKIP;
    wr_entry.seg.base = '0;
    wr_entry.seg.size = '0;
    case (cmd)
      CMD_ADD: begin
        if (usable && seg_end >= cfg.kernel_end) begin
          wr_entry.kind     = KIND_PUSH;
          wr_entry.seg.base = seg_start;
          wr_entry.seg.size = seg_end - seg_start;
        end
      end
      CMD_ALLOC: begin
        wr_entry.kind = KIND_ALLOC;
      end
      CMD_FREE: begin
        wr_entry.kind     = KIND_PUSH;
        wr_entry.seg.base = freed_frame;
        wr_entry.seg.size = cfg.frame_bytes;
      end
      default: begin
        wr_entry.kind = KIND_SKIP;
      end
    endcase
  end

  assign wr_valid = in_valid;
  assign in_ready = wr_ready;

endmodule

`default_nettype wire

@@ design/pfsa_queue.sv @@
`default_nettype none

module pfsa_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                wr_valid,
  output logic                     wr_ready,
  input  wire pfsa_pkg::q_entry_t  wr_entry,
  output logic                     rd_valid,
  input  wire logic                rd_ready,
  output pfsa_pkg::q_entry_t       rd_entry
);
  import pfsa_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(QUEUE_DEPTH - 1);

  q_entry_t      slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          push;
  logic          pop;

  assign wr_ready = (fill != CW'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_entry = slots[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/pfsa_back.sv @@
`default_nettype none

module pfsa_back #(
  parameter int unsigned STACK_DEPTH = pfsa_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pfsa_pkg::cfg_t      cfg,
  input  wire logic                rd_valid,
  output logic                     rd_ready,
  input  wire pfsa_pkg::q_entry_t  rd_entry,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [1:0]               status,
  output logic [31:0]              frame_addr,
  output logic [31:0]              pushed_start,
  output logic [31:0]              pushed_size
);
  import pfsa_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  localparam logic S_EXEC   = 1'b0;
  localparam logic S_RELOAD = 1'b1;

  // The top entry lives in registers; entries below it live in the memory.
  seg_t          mem [STACK_DEPTH];
  seg_t          rd_data;
  seg_t          top;
  logic [CW-1:0] count;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] count_m2;
  logic          state;
  logic          go;
  logic          full;
  logic          empty;
  logic          shrink;
  logic          mem_we;
  logic [1:0]    res_status;
  logic [31:0]   res_frame;
  logic [31:0]   res_start;
  logic [31:0]   res_size;

  assign count_m1 = count - 1'b1;
  assign count_m2 = count - 2'd2;
  assign full     = (count == CW'(STACK_DEPTH));
  assign empty    = (count == '0);
  assign shrink   = (top.size > cfg.frame_bytes);
  assign go       = rd_valid && (state == S_EXEC) && (!out_valid || out_ready);
  assign rd_ready = go;
  assign mem_we   = go && (rd_entry.kind == KIND_PUSH) && !full && !empty;

  always_comb begin
    res_status = ST_SKIP;
    res_frame  = '0;
    res_start  = '0;
    res_size   = '0;
    case (rd_entry.kind)
      KIND_PUSH: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_status = ST_DONE;
          res_start  = rd_entry.seg.base;
          res_size   = rd_entry.seg.size;
        end
      end
      KIND_ALLOC: begin
        if (empty) begin
          res_status = ST_OOM;
        end else begin
          res_status = ST_DONE;
          res_frame  = top.base;
        end
      end
      default: begin
        res_status = ST_SKIP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_m1[AW-1:0]] <= top;
    end
    rd_data <= mem[count_m2[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      state     <= S_EXEC;
      out_valid <= 1'b0;
    end else begin
      if (go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_RELOAD) begin
        state <= S_EXEC;
      end else if (go) begin
        if (rd_entry.kind == KIND_PUSH && !full) begin
          count <= count + 1'b1;
        end else if (rd_entry.kind == KIND_ALLOC && !empty && !shrink) begin
          count <= count_m1;
          if (count_m1 != '0) begin
            state <= S_RELOAD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RELOAD) begin
      top <= rd_data;
    end else if (go) begin
      if (rd_entry.kind == KIND_PUSH && !full) begin
        top <= rd_entry.seg;
      end else if (rd_entry.kind == KIND_ALLOC && !empty && shrink) begin
        top.base <= top.base + cfg.frame_bytes;
        top.size <= top.size - cfg.frame_bytes;
      end
    end
    if (go) begin
      status       <= res_status;
      frame_addr   <= res_frame;
      pushed_start <= res_start;
      pushed_size  <= res_size;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_reload_once: assert property (@(posedge clk) disable iff (rst)
    state == S_RELOAD |=> state == S_EXEC)
    else $error("reload lasted more than one cycle");

  a_reload_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_RELOAD |-> count != '0)
    else $error("reload with an empty stack");

  a_oom_result: assert property (@(posedge clk) disable iff (rst)
    go && rd_entry.kind == KIND_ALLOC && empty |=> out_valid && status == ST_OOM)
    else $error("allocate from empty stack did not report out of memory");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !go)
    else $error("new result while the previous one is stalled");
`endif

endmodule

`default_nettype wire

@@ design/physical_frame_stack_allocator_top.sv @@
// Physical frame stack allocator.
// Requests arrive on a valid/ready channel: cmd selects add region (0), allocate
// (1) or free (2); the region fields are used by add region, freed_frame by free.
// Every request gives exactly one result on the output valid/ready channel:
// status, frame_addr, pushed_start and pushed_size.
// A request is accepted into a two-entry queue after classification; the stack
// engine takes it from the queue and registers its result in the result
// register. An allocate that empties its top segment while older segments
// remain passes through a reload state, in which the next entry is read from
// the stack memory port; the engine takes no new request while it reloads or
// while a result is stalled.
// Reset clears the stack to empty, empties the queue and loads the registers
// with kernel_end 0x00100000, frame_bytes 4096 and usable_type 1; stack memory
// needs no clearing. When the receiver holds out_ready low the result register
// keeps its value, the engine waits, and the queue fills before in_ready drops.
// Configuration writes are taken at once; they must only occur while idle.
`default_nettype none

module physical_frame_stack_allocator_top #(
  parameter int unsigned STACK_DEPTH = pfsa_pkg::DEFAULT_STACK_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] region_type,
  input  wire logic [31:0] region_base_low,
  input  wire logic [31:0] region_base_high,
  input  wire logic [31:0] region_len_low,
  input  wire logic [31:0] region_len_high,
  input  wire logic [31:0] freed_frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [31:0]      frame_addr,
  output logic [31:0]      pushed_start,
  output logic [31:0]      pushed_size
);
  import pfsa_pkg::*;

  cfg_t     cfg;
  q_entry_t wr_entry;
  q_entry_t rd_entry;
  logic     wr_valid;
  logic     wr_ready;
  logic     rd_valid;
  logic     rd_ready;

  // Configuration registers; an index with no register behind it is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kernel_end  <= RST_KERNEL_END;
      cfg.frame_bytes <= RST_FRAME_BYTES;
      cfg.usable_type <= RST_USABLE_TYPE;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KERNEL_END:  cfg.kernel_end  <= cfg_data;
        CFG_FRAME_BYTES: cfg.frame_bytes <= cfg_data;
        CFG_USABLE_TYPE: cfg.usable_type <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The front end clips memory-map regions and sorts requests into work kinds.
  pfsa_front u_front (
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .cmd              (cmd),
    .region_type      (region_type),
    .region_base_low  (region_base_low),
    .region_base_high (region_base_high),
    .region_len_low   (region_len_low),
    .region_len_high  (region_len_high),
    .freed_frame      (freed_frame),
    .cfg              (cfg),
    .wr_valid         (wr_valid),
    .wr_ready         (wr_ready),
    .wr_entry         (wr_entry)
  );

  // The queue lets the front end keep accepting while the engine is busy.
  pfsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_entry (wr_entry),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_entry (rd_entry)
  );

  // The engine owns the segment stack and the result register.
  pfsa_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .rd_valid     (rd_valid),
    .rd_ready     (rd_ready),
    .rd_entry     (rd_entry),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .frame_addr   (frame_addr),
    .pushed_start (pushed_start),
    .pushed_size  (pushed_size)
  );

endmodule

`default_nettype wire
